// ===== hdl/spfs_pkg.sv =====
// Shared types and codes for the strict priority FIFO scheduler.
`timescale 1ns / 1ps

package spfs_pkg;

    localparam int PRIO_W = 2;

    localparam logic KIND_CREATE = 1'b0;
    localparam logic KIND_SCHED  = 1'b1;

    localparam logic [1:0] SW_NONE = 2'd0;
    localparam logic [1:0] SW_SWAP = 2'd1;
    localparam logic [1:0] SW_SET  = 2'd2;

    typedef struct packed {
        logic              is_sched;
        logic              push_en;
        logic              has_cur;
        logic [PRIO_W-1:0] level;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_FINISH
    } back_state_t;

endpackage

// ===== hdl/strict_priority_fifo_scheduler_unit.sv =====
// Top level of the strict priority FIFO scheduler: front decoder, command queue and back end.
//
//  Channel   Handshake                  Beat contents
//  item      item_valid / item_ready    kind, thread_id, priority_req, has_current, blocked
//  result    result_valid / result_ready dispatched, next_id, next_priority, switch_kind, overflow
//
// Each item passes through the back end in order: ST_IDLE updates the level queues and
// reads the id memory, ST_FINISH loads the result register once the output is free; the
// back end takes no new command until the current item has left ST_FINISH.
// A two-entry command queue lets the front keep taking beats while a result stalls.
// Reset empties every level queue at once; the id memory itself needs no clearing.
// A stalled result holds the back end, and the front stalls once its queue is full.
`timescale 1ns / 1ps

module strict_priority_fifo_scheduler_unit #(
    parameter int NUM_LEVELS  = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  kind,
    input  logic [ID_BITS-1:0]    thread_id,
    input  logic [1:0]            priority_req,
    input  logic                  has_current,
    input  logic                  blocked,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic                  dispatched,
    output logic [ID_BITS-1:0]    next_id,
    output logic [1:0]            next_priority,
    output logic [1:0]            switch_kind,
    output logic                  overflow
);

    logic               cmd_valid;
    spfs_pkg::cmd_t     cmd;
    logic [ID_BITS-1:0] cmd_id;
    logic               cmd_pop;

    spfs_front #(
        .NUM_LEVELS (NUM_LEVELS),
        .ID_BITS    (ID_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .thread_id    (thread_id),
        .priority_req (priority_req),
        .has_current  (has_current),
        .blocked      (blocked),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_id       (cmd_id),
        .cmd_pop      (cmd_pop)
    );

    spfs_back #(
        .NUM_LEVELS  (NUM_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_id        (cmd_id),
        .cmd_pop       (cmd_pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .dispatched    (dispatched),
        .next_id       (next_id),
        .next_priority (next_priority),
        .switch_kind   (switch_kind),
        .overflow      (overflow)
    );

endmodule

// ===== hdl/spfs_front.sv =====
// Front end: accepts beats, decodes them into commands and buffers them in a short queue.
`timescale 1ns / 1ps

module spfs_front #(
    parameter int NUM_LEVELS = 4,
    parameter int ID_BITS    = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  kind,
    input  logic [ID_BITS-1:0]    thread_id,
    input  logic [1:0]            priority_req,
    input  logic                  has_current,
    input  logic                  blocked,
    output logic                  cmd_valid,
    output spfs_pkg::cmd_t        cmd,
    output logic [ID_BITS-1:0]    cmd_id,
    input  logic                  cmd_pop
);

    spfs_pkg::cmd_t     q_cmd_reg [2];
    logic [ID_BITS-1:0] q_id_reg  [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    spfs_pkg::cmd_t     dec_cmd;
    logic               accept;

    always_comb
    begin
        dec_cmd.is_sched = (kind == spfs_pkg::KIND_SCHED);
        dec_cmd.push_en  = (kind == spfs_pkg::KIND_CREATE) || (has_current && !blocked);
        dec_cmd.has_cur  = has_current;
        // Levels beyond the configured count fold onto the least urgent level.
        if (32'(priority_req) >= NUM_LEVELS)
            dec_cmd.level = spfs_pkg::PRIO_W'(NUM_LEVELS - 1);
        else
            dec_cmd.level = priority_req;
    end

    assign item_ready = (count_reg != 2'd2);
    assign accept     = item_valid && item_ready;
    assign cmd_valid  = (count_reg != 2'd0);
    assign cmd        = q_cmd_reg[rd_ptr_reg];
    assign cmd_id     = q_id_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(accept) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_cmd_reg[wr_ptr_reg] <= dec_cmd;
            q_id_reg[wr_ptr_reg]  <= thread_id;
        end
    end

endmodule

// ===== hdl/spfs_back.sv =====
// Back end: per-level FIFO pointers, the shared id memory and the result register.
`timescale 1ns / 1ps

module spfs_back #(
    parameter int NUM_LEVELS  = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  spfs_pkg::cmd_t        cmd,
    input  logic [ID_BITS-1:0]    cmd_id,
    output logic                  cmd_pop,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic                  dispatched,
    output logic [ID_BITS-1:0]    next_id,
    output logic [1:0]            next_priority,
    output logic [1:0]            switch_kind,
    output logic                  overflow
);

    localparam int LVL_W     = $clog2(NUM_LEVELS);
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    spfs_pkg::back_state_t state_reg, state_next;

    logic [PTR_W-1:0] head_reg [NUM_LEVELS];
    logic [PTR_W-1:0] head_next [NUM_LEVELS];
    logic [PTR_W-1:0] tail_reg [NUM_LEVELS];
    logic [PTR_W-1:0] tail_next [NUM_LEVELS];
    logic [CNT_W-1:0] fill_reg [NUM_LEVELS];
    logic [CNT_W-1:0] fill_next [NUM_LEVELS];

    logic [ID_BITS-1:0] mem [MEM_DEPTH];
    logic [ID_BITS-1:0] rd_data_reg;

    logic                       exec;
    logic [LVL_W-1:0]           push_lvl;
    logic [NUM_LEVELS-1:0]      full_vec;
    logic [NUM_LEVELS-1:0]      empty_vec;
    logic [NUM_LEVELS-1:0]      avail_vec;
    logic [NUM_LEVELS-1:0]      push_hit;
    logic [NUM_LEVELS-1:0]      pop_hit;
    logic                       push_ok;
    logic                       push_full;
    logic                       found;
    logic                       pop_any;
    logic [LVL_W-1:0]           pop_lvl;
    logic [spfs_pkg::PRIO_W-1:0] pop_prio;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;

    // Pending result, captured while the memory read is in flight.
    logic               p_disp_reg;
    logic [1:0]         p_prio_reg;
    logic [1:0]         p_kind_reg;
    logic               p_ovf_reg;
    logic               p_byp_reg;
    logic [ID_BITS-1:0] p_byp_id_reg;

    logic               res_valid_reg, res_valid_next;
    logic               load_res;
    logic               res_disp_reg;
    logic [ID_BITS-1:0] res_id_reg;
    logic [1:0]         res_prio_reg;
    logic [1:0]         res_kind_reg;
    logic               res_ovf_reg;

    assign push_lvl = LVL_W'(cmd.level);

    always_comb
    begin
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            full_vec[l]  = (fill_reg[l] == CNT_W'(QUEUE_DEPTH));
            empty_vec[l] = (fill_reg[l] == '0);
        end
        push_full = cmd.push_en && full_vec[push_lvl];
        push_ok   = cmd.push_en && !full_vec[push_lvl];
        for (int l = 0; l < NUM_LEVELS; l++)
            avail_vec[l] = !empty_vec[l] || (push_ok && push_lvl == LVL_W'(l));

        found    = 1'b0;
        pop_lvl  = '0;
        pop_prio = '0;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            if (!found && avail_vec[l])
            begin
                found    = 1'b1;
                pop_lvl  = LVL_W'(l);
                pop_prio = spfs_pkg::PRIO_W'(l);
            end
        end
        pop_any = found && cmd.is_sched;
    end

    always_comb
    begin
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            push_hit[l] = exec && push_ok && (push_lvl == LVL_W'(l));
            pop_hit[l]  = exec && pop_any && (pop_lvl == LVL_W'(l));
            fill_next[l] = fill_reg[l] + CNT_W'(push_hit[l]) - CNT_W'(pop_hit[l]);
            if (push_hit[l])
                tail_next[l] = (tail_reg[l] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg[l] + 1'b1;
            else
                tail_next[l] = tail_reg[l];
            if (pop_hit[l])
                head_next[l] = (head_reg[l] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg[l] + 1'b1;
            else
                head_next[l] = head_reg[l];
        end
    end

    assign wr_addr = ADDR_W'(push_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_reg[push_lvl]);
    assign rd_addr = ADDR_W'(pop_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_reg[pop_lvl]);

    // Back sequencer: ST_IDLE updates the queues and launches the read,
    // ST_FINISH moves the result into the output register once that register is free.
    always_comb
    begin
        state_next = state_reg;
        exec       = 1'b0;
        load_res   = 1'b0;
        unique case (state_reg)
            spfs_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    exec       = 1'b1;
                    state_next = spfs_pkg::ST_FINISH;
                end
            end
            spfs_pkg::ST_FINISH:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    load_res   = 1'b1;
                    state_next = spfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spfs_pkg::ST_IDLE;
            end
        endcase
    end

    assign cmd_pop = exec;

    always_comb
    begin
        if (load_res)
            res_valid_next = 1'b1;
        else if (result_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spfs_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                fill_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l] <= head_next[l];
                tail_reg[l] <= tail_next[l];
                fill_reg[l] <= fill_next[l];
            end
        end
    end

    // A read that hits the entry written in the same cycle returns stale data,
    // which only happens when the pop drains a queue that was empty; that case
    // takes the id straight from the command.
    always_ff @(posedge clk)
    begin
        if (exec && push_ok)
            mem[wr_addr] <= cmd_id;
        if (exec && pop_any)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            p_disp_reg   <= pop_any;
            p_prio_reg   <= pop_any ? pop_prio : '0;
            p_kind_reg   <= pop_any ? (cmd.has_cur ? spfs_pkg::SW_SWAP : spfs_pkg::SW_SET)
                                    : spfs_pkg::SW_NONE;
            p_ovf_reg    <= push_full;
            p_byp_reg    <= push_ok && (pop_lvl == push_lvl) && empty_vec[push_lvl];
            p_byp_id_reg <= cmd_id;
        end
        if (load_res)
        begin
            res_disp_reg <= p_disp_reg;
            res_id_reg   <= p_disp_reg ? (p_byp_reg ? p_byp_id_reg : rd_data_reg) : '0;
            res_prio_reg <= p_prio_reg;
            res_kind_reg <= p_kind_reg;
            res_ovf_reg  <= p_ovf_reg;
        end
    end

    assign result_valid  = res_valid_reg;
    assign dispatched    = res_disp_reg;
    assign next_id       = res_id_reg;
    assign next_priority = res_prio_reg;
    assign switch_kind   = res_kind_reg;
    assign overflow      = res_ovf_reg;

endmodule

// ===== hdl/spfs_checker.sv =====
// Port-level checks for the scheduler, bound to the top level.
`timescale 1ns / 1ps

module spfs_checker #(
    parameter int ID_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               result_valid,
    input  logic               result_ready,
    input  logic               dispatched,
    input  logic [ID_BITS-1:0] next_id,
    input  logic [1:0]         next_priority,
    input  logic [1:0]         switch_kind,
    input  logic               overflow
);

    // A stalled result beat keeps its id, dispatch flag, switch kind and overflow flag.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(next_id)
            && $stable(dispatched) && $stable(switch_kind) && $stable(overflow))
        else $error("result beat changed while stalled");

    // A beat without a dispatch carries no thread and no level.
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !dispatched |-> next_id == '0 && next_priority == 2'd0)
        else $error("undispatched result carries a thread");

    // The switch code agrees with the dispatch flag.
    a_switch_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> dispatched == (switch_kind != spfs_pkg::SW_NONE))
        else $error("switch kind disagrees with dispatch");

    a_switch_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> switch_kind == spfs_pkg::SW_NONE || switch_kind == spfs_pkg::SW_SWAP
            || switch_kind == spfs_pkg::SW_SET)
        else $error("switch kind out of range");

endmodule

bind strict_priority_fifo_scheduler_unit spfs_checker #(
    .ID_BITS (ID_BITS)
) u_spfs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .dispatched    (dispatched),
    .next_id       (next_id),
    .next_priority (next_priority),
    .switch_kind   (switch_kind),
    .overflow      (overflow)
);

// ===== dv/strict_priority_fifo_scheduler_unit_tb.sv =====
// Self-checking testbench for the strict priority FIFO scheduler.
`timescale 1ns / 1ps

module strict_priority_fifo_scheduler_unit_tb;

    localparam int LEVELS         = 4;
    localparam int DEPTH          = 16;
    localparam int ID_W           = 8;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int HOLD_OFF_AFTER = 400;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] thread_id;
        logic [1:0]      priority_req;
        logic            has_current;
        logic            blocked;
    } sched_item_t;

    typedef struct packed {
        logic            dispatched;
        logic [ID_W-1:0] next_id;
        logic [1:0]      next_priority;
        logic [1:0]      switch_kind;
        logic            overflow;
    } dispatch_t;

    typedef struct {
        sched_item_t item;
        int          reps;
        bit          known;
        dispatch_t   want;
    } table_row_t;

    typedef enum int {
        PH_FLOOD,
        PH_DRAIN,
        PH_MIXED
    } load_phase_t;

    logic            clk;
    logic            rst_n;
    logic            item_valid;
    logic            item_ready;
    logic            kind;
    logic [ID_W-1:0] thread_id;
    logic [1:0]      priority_req;
    logic            has_current;
    logic            blocked;
    logic            result_valid;
    logic            result_ready;
    logic            dispatched;
    logic [ID_W-1:0] next_id;
    logic [1:0]      next_priority;
    logic [1:0]      switch_kind;
    logic            overflow;

    // Shadow copy of the level queues and of the running thread.
    logic [ID_W-1:0] level_ids [LEVELS][DEPTH];
    int              level_head [LEVELS];
    int              level_tail [LEVELS];
    int              level_fill [LEVELS];
    logic [ID_W-1:0] run_id;
    logic [1:0]      run_level;
    logic            run_valid;

    dispatch_t  expected_dispatches[$];
    table_row_t directed_rows[$];
    int         err_count;
    int         beat_count;
    int         items_taken;
    int         quiet_cycles;
    int         burst_left;

    strict_priority_fifo_scheduler_unit #(
        .NUM_LEVELS  (LEVELS),
        .QUEUE_DEPTH (DEPTH),
        .ID_BITS     (ID_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .kind          (kind),
        .thread_id     (thread_id),
        .priority_req  (priority_req),
        .has_current   (has_current),
        .blocked       (blocked),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .dispatched    (dispatched),
        .next_id       (next_id),
        .next_priority (next_priority),
        .switch_kind   (switch_kind),
        .overflow      (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic level_append(int lvl, logic [ID_W-1:0] id);
        if (level_fill[lvl] >= DEPTH)
            return 1'b1;
        level_ids[lvl][level_tail[lvl]] = id;
        level_tail[lvl] = (level_tail[lvl] + 1) % DEPTH;
        level_fill[lvl]++;
        return 1'b0;
    endfunction

    function automatic dispatch_t predict_dispatch(sched_item_t it);
        dispatch_t r;
        int        lvl;
        int        pick;
        r = '0;
        lvl = (it.priority_req >= LEVELS) ? LEVELS - 1 : int'(it.priority_req);
        if (it.kind == spfs_pkg::KIND_CREATE)
            r.overflow = level_append(lvl, it.thread_id);
        else
        begin
            if (it.has_current && !it.blocked)
                r.overflow = level_append(lvl, it.thread_id);
            pick = LEVELS;
            for (int k = LEVELS - 1; k >= 0; k--)
                if (level_fill[k] != 0)
                    pick = k;
            if (pick < LEVELS)
            begin
                r.dispatched    = 1'b1;
                r.next_id       = level_ids[pick][level_head[pick]];
                r.next_priority = 2'(pick);
                r.switch_kind   = it.has_current ? spfs_pkg::SW_SWAP : spfs_pkg::SW_SET;
                level_head[pick] = (level_head[pick] + 1) % DEPTH;
                level_fill[pick]--;
                run_id    = r.next_id;
                run_level = r.next_priority;
                run_valid = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void add_row(logic k, logic [ID_W-1:0] id, logic [1:0] prio,
                                    logic hc, logic blk, int reps, bit known,
                                    logic disp, logic [ID_W-1:0] nid, logic [1:0] nprio,
                                    logic [1:0] sw, logic ovf);
        table_row_t row;
        row.item  = '{k, id, prio, hc, blk};
        row.reps  = reps;
        row.known = known;
        row.want  = '{disp, nid, nprio, sw, ovf};
        directed_rows.push_back(row);
    endfunction

    // Schedules mostly carry the thread that was last dispatched, as a real kernel would.
    function automatic sched_item_t next_random_item(load_phase_t phase, int flood_lvl);
        sched_item_t it;
        int          id_roll;
        int          create_pct;
        id_roll = $urandom_range(0, 9);
        it.thread_id    = (id_roll == 0) ? '0 : (id_roll == 1) ? '1 : ID_W'($urandom());
        it.priority_req = 2'($urandom_range(0, 3));
        it.has_current  = 1'($urandom_range(0, 1));
        it.blocked      = 1'($urandom_range(0, 1));
        it.kind         = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 10)
            return it;
        create_pct = (phase == PH_FLOOD) ? 85 : (phase == PH_DRAIN) ? 15 : 45;
        if ($urandom_range(0, 99) < create_pct)
        begin
            it.kind = spfs_pkg::KIND_CREATE;
            if (phase == PH_FLOOD && $urandom_range(0, 3) != 0)
                it.priority_req = 2'(flood_lvl);
        end
        else
        begin
            it.kind        = spfs_pkg::KIND_SCHED;
            it.has_current = run_valid;
            if (run_valid)
            begin
                it.thread_id    = run_id;
                it.priority_req = run_level;
            end
            it.blocked = ($urandom_range(0, 99) < ((phase == PH_DRAIN) ? 60 : 25));
        end
        return it;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        if (err_count <= 50)
            $display("[%0t] result beat %0d: %s got 0x%0h, expected 0x%0h",
                     $time, beat_count, what, got, want);
    endtask

    task automatic check_dispatch(dispatch_t got, dispatch_t want);
        if (got.dispatched !== want.dispatched)
            report_mismatch("dispatched", got.dispatched, want.dispatched);
        if (got.next_id !== want.next_id)
            report_mismatch("next_id", got.next_id, want.next_id);
        if (got.next_priority !== want.next_priority)
            report_mismatch("next_priority", got.next_priority, want.next_priority);
        if (got.switch_kind !== want.switch_kind)
            report_mismatch("switch_kind", got.switch_kind, want.switch_kind);
        if (got.overflow !== want.overflow)
            report_mismatch("overflow", got.overflow, want.overflow);
    endtask

    // Drives one beat and holds it until accepted. Ready is looked at on the falling
    // edge, where it already shows what the next rising edge will see.
    task automatic offer(sched_item_t it, bit known, dispatch_t want);
        bit        taken;
        dispatch_t predicted;
        item_valid   <= 1'b1;
        kind         <= it.kind;
        thread_id    <= it.thread_id;
        priority_req <= it.priority_req;
        has_current  <= it.has_current;
        blocked      <= it.blocked;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = item_ready;
            if (taken)
            begin
                predicted = predict_dispatch(it);
                expected_dispatches.push_back(known ? want : predicted);
                items_taken++;
            end
            @(posedge clk);
        end
    endtask

    task automatic pace_sender();
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
    endtask

    initial
    begin : stimulus
        sched_item_t it;
        load_phase_t phase;
        int          seg_left;
        int          flood_lvl;
        for (int l = 0; l < LEVELS; l++)
        begin
            level_head[l] = 0;
            level_tail[l] = 0;
            level_fill[l] = 0;
        end
        run_id       = '0;
        run_level    = '0;
        run_valid    = 1'b0;
        err_count    = 0;
        beat_count   = 0;
        items_taken  = 0;
        burst_left   = 0;
        seg_left     = 0;
        phase        = PH_MIXED;
        flood_lvl    = 0;
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        kind         <= spfs_pkg::KIND_CREATE;
        thread_id    <= '0;
        priority_req <= '0;
        has_current  <= 1'b0;
        blocked      <= 1'b0;

        // Empty queues, blocked current, requeue and reselect, then one level run full.
        add_row(spfs_pkg::KIND_SCHED, 8'h00, 2'd0, 1'b0, 1'b0, 1, 1,
                1'b0, 8'h00, 2'd0, spfs_pkg::SW_NONE, 1'b0);
        add_row(spfs_pkg::KIND_SCHED, 8'hFF, 2'd3, 1'b1, 1'b1, 1, 1,
                1'b0, 8'h00, 2'd0, spfs_pkg::SW_NONE, 1'b0);
        add_row(spfs_pkg::KIND_CREATE, 8'hFF, 2'd3, 1'b1, 1'b1, 1, 1,
                1'b0, 8'h00, 2'd0, spfs_pkg::SW_NONE, 1'b0);
        add_row(spfs_pkg::KIND_CREATE, 8'h00, 2'd0, 1'b0, 1'b0, 1, 1,
                1'b0, 8'h00, 2'd0, spfs_pkg::SW_NONE, 1'b0);
        add_row(spfs_pkg::KIND_SCHED, 8'h3C, 2'd1, 1'b0, 1'b1, 1, 1,
                1'b1, 8'h00, 2'd0, spfs_pkg::SW_SET, 1'b0);
        add_row(spfs_pkg::KIND_SCHED, 8'hAA, 2'd0, 1'b1, 1'b0, 1, 1,
                1'b1, 8'hAA, 2'd0, spfs_pkg::SW_SWAP, 1'b0);
        add_row(spfs_pkg::KIND_SCHED, 8'h11, 2'd1, 1'b1, 1'b1, 1, 1,
                1'b1, 8'hFF, 2'd3, spfs_pkg::SW_SWAP, 1'b0);
        add_row(spfs_pkg::KIND_SCHED, 8'h55, 2'd2, 1'b1, 1'b0, 1, 1,
                1'b1, 8'h55, 2'd2, spfs_pkg::SW_SWAP, 1'b0);
        add_row(spfs_pkg::KIND_CREATE, 8'h10, 2'd2, 1'b0, 1'b0, DEPTH, 0,
                1'b0, 8'h00, 2'd0, spfs_pkg::SW_NONE, 1'b0);
        add_row(spfs_pkg::KIND_CREATE, 8'hEE, 2'd2, 1'b0, 1'b0, 1, 1,
                1'b0, 8'h00, 2'd0, spfs_pkg::SW_NONE, 1'b1);
        add_row(spfs_pkg::KIND_SCHED, 8'h77, 2'd2, 1'b1, 1'b0, 1, 1,
                1'b1, 8'h10, 2'd2, spfs_pkg::SW_SWAP, 1'b1);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            for (int k = 0; k < directed_rows[r].reps; k++)
            begin
                it = directed_rows[r].item;
                it.thread_id = it.thread_id + ID_W'(k);
                pace_sender();
                offer(it, directed_rows[r].known, directed_rows[r].want);
            end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (seg_left == 0)
            begin
                seg_left  = $urandom_range(20, 60);
                phase     = load_phase_t'($urandom_range(0, 2));
                flood_lvl = $urandom_range(0, LEVELS - 1);
            end
            seg_left--;
            pace_sender();
            offer(next_random_item(phase, flood_lvl), 1'b0, '0);
        end
        item_valid <= 1'b0;

        while (expected_dispatches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Result side: random stall patterns, plus one long hold-off that backs the block up.
    initial
    begin : result_sink
        int mode;
        int span;
        bit held_off;
        held_off = 1'b0;
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held_off && items_taken >= HOLD_OFF_AFTER)
            begin
                held_off = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = (mode == 2) ? $urandom_range(1, 6) : $urandom_range(1, 40);
            repeat (span)
            begin
                case (mode)
                    0: result_ready <= 1'b1;
                    1: result_ready <= 1'($urandom_range(0, 1));
                    2: result_ready <= 1'b0;
                    default: result_ready <= ~result_ready;
                endcase
                @(posedge clk);
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            beat_count++;
            if (expected_dispatches.size() == 0)
                report_mismatch("beat with nothing expected", 1, 0);
            else
                check_dispatch('{dispatched, next_id, next_priority, switch_kind, overflow},
                               expected_dispatches.pop_front());
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
